/* design/ujse_pkg.sv */
// ----------------------------------------------------------------------------
// ujse_pkg
// Shared types and constants for the UTF-16 to escaped UTF-8 string escaper.
// ----------------------------------------------------------------------------
package ujse_pkg;

    localparam int RUN_MAX   = 6;    // most bytes one code unit can produce
    localparam int RUN_CW    = 3;    // bits of a byte count 0..RUN_MAX
    localparam int QDEPTH    = 2;    // entries in the front/back queue
    localparam int QAW       = 1;    // queue address bits
    localparam int QCW       = 2;    // queue fill count bits 0..QDEPTH

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } t_out_item;

    // bytes for one code unit, first byte at index 0
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CW-1:0]       count;
    } t_run;

    // queue read side as seen by the back end
    typedef struct packed {
        logic valid;
        t_run run;
    } t_q_head;

endpackage

/* design/ujse_front.sv */
// ----------------------------------------------------------------------------
// ujse_front
// Accepts code units, tracks a held high surrogate and turns each unit into
// a run of up to six escaped UTF-8 bytes for the queue.
// ----------------------------------------------------------------------------
module ujse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ujse_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output ujse_pkg::t_run    o_run
);

    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CC_BS     = 8'h08;
    localparam logic [7:0] CC_FF     = 8'h0c;
    localparam logic [7:0] CC_LF     = 8'h0a;
    localparam logic [7:0] CC_CR     = 8'h0d;
    localparam logic [7:0] CC_TAB    = 8'h09;
    localparam logic [5:0] SUR_HIGH  = 6'b110110;
    localparam logic [5:0] SUR_LOW   = 6'b110111;

    function automatic logic [7:0] hex_lower(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CH_ZERO + {4'd0, v};
        end else begin
            r = 8'h57 + {4'd0, v};
        end
        return r;
    endfunction

    function automatic ujse_pkg::t_run qmark_run();
        ujse_pkg::t_run r;
        r          = '0;
        r.bytes[0] = CH_QMARK;
        r.count    = 3'd1;
        return r;
    endfunction

    function automatic ujse_pkg::t_run encode(input logic [20:0] cp);
        ujse_pkg::t_run r;
        logic           nonchar;
        r       = '0;
        nonchar = (cp >= 21'h0fdd0 && cp <= 21'h0fdef) || (cp[15:1] == 15'h7fff);
        if (cp < 21'h80) begin
            if (cp < 21'h20 || cp == 21'h22 || cp == 21'h5c) begin
                r.bytes[0] = CH_BSLASH;
                r.count    = 3'd2;
                case (cp[7:0])
                    CH_QUOTE:  r.bytes[1] = CH_QUOTE;
                    CH_BSLASH: r.bytes[1] = CH_BSLASH;
                    CC_BS:     r.bytes[1] = CH_B;
                    CC_FF:     r.bytes[1] = CH_F;
                    CC_LF:     r.bytes[1] = CH_N;
                    CC_CR:     r.bytes[1] = CH_R;
                    CC_TAB:    r.bytes[1] = CH_T;
                    default: begin
                        r.bytes[1] = CH_U;
                        r.bytes[2] = CH_ZERO;
                        r.bytes[3] = CH_ZERO;
                        r.bytes[4] = hex_lower(cp[7:4]);
                        r.bytes[5] = hex_lower(cp[3:0]);
                        r.count    = 3'd6;
                    end
                endcase
            end else begin
                r.bytes[0] = cp[7:0];
                r.count    = 3'd1;
            end
        end else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.count    = 3'd2;
        end else if (nonchar) begin
            r = qmark_run();
        end else if (cp >= 21'h10000) begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.count    = 3'd4;
        end else begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.count    = 3'd3;
        end
        return r;
    endfunction

    logic           r_held_valid, n_held_valid;
    logic [9:0]     r_held_bits, n_held_bits;
    logic           accept;
    logic           is_low;
    logic           is_high;
    logic [20:0]    pair_cp;
    ujse_pkg::t_run run;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign is_low  = (i_item.code_unit[15:10] == SUR_LOW);
    assign is_high = (i_item.code_unit[15:10] == SUR_HIGH);
    assign pair_cp = 21'h10000 + {1'b0, r_held_bits, i_item.code_unit[9:0]};

    always_comb begin
        run          = '0;
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        if (accept) begin
            if (r_held_valid) begin
                n_held_valid = 1'b0;
                n_held_bits  = '0;
                run          = is_low ? encode(pair_cp) : qmark_run();
            end else if (is_low) begin
                run = qmark_run();
            end else if (is_high) begin
                n_held_valid = 1'b1;
                n_held_bits  = i_item.code_unit[9:0];
            end else begin
                run = encode({5'd0, i_item.code_unit});
            end
            // end of string drops a dangling high surrogate
            if (i_item.final_unit) begin
                n_held_valid = 1'b0;
                n_held_bits  = '0;
            end
        end
    end

    assign o_push = accept && (run.count != '0);
    assign o_run  = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
        end
    end

`ifndef SYNTHESIS
    a_final_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.final_unit) |=> !r_held_valid)
        else $error("hold survived a final unit");
`endif

endmodule

/* design/ujse_queue.sv */
// ----------------------------------------------------------------------------
// ujse_queue
// Short queue of byte runs between the front and back ends.
// ----------------------------------------------------------------------------
module ujse_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ujse_pkg::t_run     i_run,
    output logic               o_full,
    input  logic               i_pop,
    output ujse_pkg::t_q_head  o_head
);

    ujse_pkg::t_run                  r_mem [ujse_pkg::QDEPTH];
    logic [ujse_pkg::QAW-1:0]        r_wr_ptr;
    logic [ujse_pkg::QAW-1:0]        r_rd_ptr;
    logic [ujse_pkg::QCW-1:0]        r_count;
    logic                            pop_ok;

    assign o_full       = (r_count == ujse_pkg::QCW'(ujse_pkg::QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.run   = r_mem[r_rd_ptr];
    assign pop_ok       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ujse_pkg::QCW'(ujse_pkg::QDEPTH))
        else $error("queue count past depth");
`endif

endmodule

/* design/ujse_back.sv */
// ----------------------------------------------------------------------------
// ujse_back
// Takes byte runs from the queue and sends them out one byte per cycle unless
// stalled, through an output register, marking the last byte of each run.
// ----------------------------------------------------------------------------
module ujse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ujse_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output ujse_pkg::t_out_item o_item
);

    ujse_pkg::t_run                 r_run;
    logic [ujse_pkg::RUN_CW-1:0]    r_idx;
    logic                           r_busy;
    logic                           r_out_valid;
    ujse_pkg::t_out_item            r_out;
    logic                           advance;
    logic                           last;

    // output register can take a byte
    assign advance = !r_out_valid || !i_stall;
    assign last    = (r_idx == r_run.count - 1'b1);
    assign o_pop   = i_head.valid && (!r_busy || (advance && last));
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (advance && r_busy) begin
            r_out.out_byte <= r_run.bytes[r_idx];
            r_out.run_end  <= last;
        end
        if (o_pop) begin
            r_run <= i_head.run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (advance && r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_run.count))
        else $error("byte index past run length");
`endif

endmodule

/* design/utf16_json_string_escaper_top.sv */
// ----------------------------------------------------------------------------
// utf16_json_string_escaper_top
// UTF-16 code units in, JSON-escaped UTF-8 bytes out.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_item (code_unit, final_unit). A word
// is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_item (out_byte, run_end). A word
// leaves at an edge with o_valid high and i_stall low; run_end marks the
// last byte made for one code unit. A unit makes zero to six bytes.
// The front end classifies a unit and builds its whole byte run in the cycle
// it is taken; a two-entry queue feeds the back end, which sends one byte
// per cycle while i_stall is low, through an output register. When the block
// is empty, the first byte of a unit passes the queue, the back end's run
// register and the output register. The single byte lane sends each unit's
// bytes in turn; the front end takes new units while the queue has space.
// A high surrogate is held inside the front end until the next unit; a
// final unit drops any held one.
// Reset clears the hold, the queue and the output register.
// When the receiver stalls, the output word holds, the queue fills, and then
// o_stall rises until space frees up.
// ----------------------------------------------------------------------------
module utf16_json_string_escaper_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ujse_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output ujse_pkg::t_out_item o_item
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    ujse_pkg::t_run    q_run;
    ujse_pkg::t_q_head q_head;

    ujse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_run   (q_run)
    );

    ujse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_run   (q_run),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    ujse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule
